// ===== design/wsd_pkg.sv =====
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 3;

  localparam logic [6:0] LenCodeExt16 = 7'd126;
  localparam logic [6:0] LenCodeExt64 = 7'd127;

  localparam logic [HdrCntW-1:0] Ext16LastCnt = 3'd1;
  localparam logic [HdrCntW-1:0] Ext64LastCnt = 3'd7;
  localparam logic [HdrCntW-1:0] MaskLastCnt  = 3'd3;

  typedef enum logic [6:0] {
    PhHdr0    = 7'b0000001,
    PhHdr1    = 7'b0000010,
    PhExt16   = 7'b0000100,
    PhExt64   = 7'b0001000,
    PhMask    = 7'b0010000,
    PhPayload = 7'b0100000,
    PhDone    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               byte_valid;
    logic [OpcodeW-1:0] frame_opcode;
    logic               message_end;
    logic               truncated;
  } res_t;

endpackage

// ===== design/wsd_if.sv =====
interface wsd_in_if;
  import wsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface wsd_out_if;
  import wsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   out_byte;
  logic               byte_valid;
  logic [OpcodeW-1:0] frame_opcode;
  logic               message_end;
  logic               truncated;

  modport source (output valid, output out_byte, output byte_valid, output frame_opcode,
                  output message_end, output truncated, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input frame_opcode,
                  input message_end, input truncated, output ready);
endinterface

// ===== design/websocket_frame_deframer_unmask.sv =====
// Channel | Dir | Payload                                                  | Transaction
// in_i    | in  | in_byte, buffer_end                                      | valid && ready
// out_o   | out | out_byte, byte_valid, frame_opcode, message_end, truncated | valid && ready
//
// One byte is taken per cycle while in_i is ready; the header parser and unmask XOR sit in one stage
// between the parser state registers and the result registers.
// A result is registered into the head entry, or into the skid entry while the head is held, before it shows on out_o.
// A two-entry result buffer decouples the sides; in_i stalls only when both entries are full.
// Reset is asynchronous and returns the parser to the first header byte with no results held.
module websocket_frame_deframer_unmask #(
  parameter int unsigned LEN_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  wsd_in_if.sink           in_i,
  wsd_out_if.source        out_o
);
  import wsd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [HdrCntW-1:0]     cnt_q, cnt_d;
  logic [OpcodeW-1:0]     opcode_q, opcode_d;
  logic                   masked_q, masked_d;
  logic [LEN_WIDTH-1:0]   rem_q, rem_d;
  logic                   ovf_q, ovf_d;
  logic [KeyW-1:0]        key_q, key_d;
  logic [1:0]             idx_q, idx_d;

  logic [LEN_WIDTH-1:0]   ext_len;
  logic                   ext_ovf;
  logic                   len_done;
  logic [ByteW-1:0]       key_byte;
  logic                   emit;
  res_t                   res;

  res_t                   head_q, head_d, skid_q, skid_d;
  logic                   head_v_q, head_v_d, skid_v_q, skid_v_d;
  logic                   in_acc, push, pop;

  assign in_i.ready = !skid_v_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign pop        = head_v_q && out_o.ready;
  assign push       = in_acc && emit;

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    key_d    = key_q;
    idx_d    = idx_q;
    len_done = 1'b0;
    emit     = 1'b0;
    res      = '0;
    ext_len  = {rem_q[LEN_WIDTH-9:0], in_i.in_byte};
    ext_ovf  = ovf_q | (|rem_q[LEN_WIDTH-1:LEN_WIDTH-8]);

    unique case (phase_q) inside
      PhHdr0: begin
        opcode_d = in_i.in_byte[OpcodeW-1:0];
        masked_d = 1'b0;
        rem_d    = '0;
        ovf_d    = 1'b0;
        key_d    = '0;
        idx_d    = '0;
        cnt_d    = '0;
        phase_d  = PhHdr1;
      end
      PhHdr1: begin
        masked_d = in_i.in_byte[7];
        cnt_d    = '0;
        ovf_d    = 1'b0;
        rem_d    = '0;
        if (in_i.in_byte[6:0] == LenCodeExt16) begin
          phase_d = PhExt16;
        end else if (in_i.in_byte[6:0] == LenCodeExt64) begin
          phase_d = PhExt64;
        end else begin
          rem_d    = {{(LEN_WIDTH-7){1'b0}}, in_i.in_byte[6:0]};
          len_done = 1'b1;
        end
      end
      PhExt16, PhExt64: begin
        rem_d = ext_len;
        ovf_d = ext_ovf;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == ((phase_q == PhExt16) ? Ext16LastCnt : Ext64LastCnt)) begin
          len_done = 1'b1;
        end
      end
      PhMask: begin
        key_d = {key_q[KeyW-9:0], in_i.in_byte};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == MaskLastCnt) begin
          cnt_d = '0;
          if (rem_q == '0) begin
            phase_d         = PhDone;
            emit            = 1'b1;
            res.message_end = 1'b1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        res.out_byte   = in_i.in_byte ^ (masked_q ? key_byte : '0);
        res.byte_valid = 1'b1;
        emit           = 1'b1;
        idx_d          = idx_q + 2'd1;
        if (rem_q != '0) begin
          rem_d = rem_q - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
        end
        if (rem_d == '0) begin
          res.message_end = 1'b1;
          phase_d         = PhDone;
        end
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = PhDone;
      end
    endcase

    if (len_done) begin
      if (ovf_d) begin
        rem_d = '1;
      end
      ovf_d = 1'b0;
      cnt_d = '0;
      if (masked_d) begin
        phase_d = PhMask;
      end else if (rem_d == '0) begin
        phase_d         = PhDone;
        emit            = 1'b1;
        res.message_end = 1'b1;
      end else begin
        phase_d = PhPayload;
      end
    end

    if (in_i.buffer_end) begin
      if (phase_d != PhDone) begin
        emit            = 1'b1;
        res.truncated   = 1'b1;
        res.message_end = 1'b0;
      end
      phase_d = PhHdr0;
    end

    res.frame_opcode = opcode_d;
  end

  always_comb begin
    head_d   = head_q;
    head_v_d = head_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!head_v_q || pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        head_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        head_d   = res;
        head_v_d = push;
      end
    end else if (push) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      cnt_q    <= '0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      ovf_q    <= 1'b0;
      key_q    <= '0;
      idx_q    <= '0;
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        opcode_q <= opcode_d;
        masked_q <= masked_d;
        rem_q    <= rem_d;
        ovf_q    <= ovf_d;
        key_q    <= key_d;
        idx_q    <= idx_d;
      end
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_o.valid        = head_v_q;
  assign out_o.out_byte     = head_q.out_byte;
  assign out_o.byte_valid   = head_q.byte_valid;
  assign out_o.frame_opcode = head_q.frame_opcode;
  assign out_o.message_end  = head_q.message_end;
  assign out_o.truncated    = head_q.truncated;

endmodule

// ===== design/wsd_checker.sv =====
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic [3:0] frame_opcode_i,
  input logic       message_end_i,
  input logic       truncated_i
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(byte_valid_i) && $stable(frame_opcode_i)
      && $stable(message_end_i) && $stable(truncated_i))
    else $error("stalled result changed");

  // A result without data carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> out_byte_i == 8'd0)
    else $error("nonzero byte without byte_valid");

  // A frame cannot both complete and be truncated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(message_end_i && truncated_i))
    else $error("message_end and truncated together");

  // A result without data either closes an empty frame or reports truncation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> message_end_i || truncated_i)
    else $error("empty result with no meaning");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result pending after reset");

endmodule

bind websocket_frame_deframer_unmask wsd_checker u_wsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .byte_valid_i   (out_o.byte_valid),
  .frame_opcode_i (out_o.frame_opcode),
  .message_end_i  (out_o.message_end),
  .truncated_i    (out_o.truncated)
);
